### src/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the semaphore design.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// The consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

### src/csq_pkg.sv
// -----------------------------------------------------------------------------
// Counting semaphore package
// Operation and status codes, field widths and default sizes.
// -----------------------------------------------------------------------------
package csq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;

   localparam int OP_W        = 2;
   localparam int STATUS_W    = 3;
   localparam int INIT_W      = 16;
   localparam int COUNT_W     = 18;
   localparam int COUNT_NOW_W = 17;
   localparam int COUNT_MAX   = 65535;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_WAIT      = 2'd0;
   localparam op_type OP_SIGNAL    = 2'd1;
   localparam op_type OP_SIGNAL_ID = 2'd2;
   localparam op_type OP_REOPEN    = 2'd3;

   localparam status_type ST_PROCEED   = 3'd0;
   localparam status_type ST_BLOCKED   = 3'd1;
   localparam status_type ST_RELEASED  = 3'd2;
   localparam status_type ST_NONE      = 3'd3;
   localparam status_type ST_DEAD      = 3'd4;
   localparam status_type ST_OVERFLOW  = 3'd5;
   localparam status_type ST_SATURATED = 3'd6;

endpackage

### src/csq_queue_ram.sv
// -----------------------------------------------------------------------------
// Wait queue memory
// Single write port, single read port memory with a registered read.
// -----------------------------------------------------------------------------
module csq_queue_ram #(
   parameter int  DEPTH  = csq_pkg::QUEUE_DEPTH,
   parameter int  WIDTH  = csq_pkg::ID_BITS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/counting_semaphore_wait_queue.sv
// -----------------------------------------------------------------------------
// Counting semaphore with FIFO wait queue
// A wait, signal, named signal or reopen word goes in; one result word comes
// out per operation or per waiter a reopen frees, the last word of each marked.
// -----------------------------------------------------------------------------
// The blocked thread ids sit in a single-port-read memory kept in arrival order,
// and every operation is handled one at a time by a small sequencer. A wait, or
// a signal that releases nobody, is settled in the decide state.
// A signal that releases the oldest waiter, or a named signal, reads the queue
// one entry per cycle through the memory's read port to find the entry and then
// moves each younger entry down by one. A reopen streams one dead-release word
// per queued entry, one per cycle while the result side keeps up. A result word
// waits in an output register, and the sequencer stalls only when it needs to
// place a new word while the previous one has not been taken.
`include "assert_macros.svh"

module counting_semaphore_wait_queue #(
   parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH,
   parameter int ID_BITS     = csq_pkg::ID_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  csq_pkg::op_type                     req_op,
   input  logic [ID_BITS-1:0]                  req_thread_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output csq_pkg::status_type                 rsp_status,
   output logic [ID_BITS-1:0]                  rsp_released_id,
   output logic signed [csq_pkg::COUNT_NOW_W-1:0] rsp_count_now,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [csq_pkg::INIT_W-1:0]          csr_init_value
);

   import csq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;
   localparam logic [2:0] S_DEAD   = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic signed [COUNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   logic [PTR_W-1:0]          idx_ff, idx_in;
   logic [ID_BITS-1:0]        rel_ff, rel_in;
   op_type                    op_ff, op_in;
   logic [ID_BITS-1:0]        tid_ff, tid_in;
   logic [INIT_W-1:0]         init_ff;

   logic                      rsp_valid_ff;
   status_type                rsp_status_ff, st_in;
   logic [ID_BITS-1:0]        rsp_id_ff, id_in;
   logic [COUNT_NOW_W-1:0]    rsp_count_ff;
   logic                      rsp_last_ff, last_in;

   logic                      rd_en, wr_en;
   logic [PTR_W-1:0]          rd_addr, wr_addr;
   logic [ID_BITS-1:0]        rd_data, wr_data;

   logic                      emit, out_free, more, count_le0;
   logic [CNT_W-1:0]          idx_nx;
   logic signed [COUNT_W:0]   balance;

   csq_queue_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ID_BITS)
   ) u_queue (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign idx_nx    = CNT_W'(idx_ff) + CNT_W'(1);
   assign more      = idx_nx < occ_ff;
   assign count_le0 = count_ff[COUNT_W-1] || (count_ff == '0);
   assign balance   = {count_ff[COUNT_W-1], count_ff} + (COUNT_W + 1)'(occ_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      occ_in   = occ_ff;
      idx_in   = idx_ff;
      rel_in   = rel_ff;
      op_in    = op_ff;
      tid_in   = tid_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_nx[PTR_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = occ_ff[PTR_W-1:0];
      wr_data  = tid_ff;
      emit     = 1'b0;
      st_in    = ST_PROCEED;
      id_in    = '0;
      last_in  = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               tid_in   = req_thread_id;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (op_ff)
               OP_WAIT: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     if (count_le0) begin
                        if (occ_ff == CNT_W'(QUEUE_DEPTH)) begin
                           st_in = ST_OVERFLOW;
                        end else begin
                           count_in = count_ff - COUNT_W'(1);
                           wr_en    = 1'b1;
                           occ_in   = occ_ff + CNT_W'(1);
                           st_in    = ST_BLOCKED;
                        end
                     end else begin
                        count_in = count_ff - COUNT_W'(1);
                        st_in    = ST_PROCEED;
                     end
                  end
               end
               OP_SIGNAL, OP_SIGNAL_ID: begin
                  if (count_ff == COUNT_W'(COUNT_MAX)) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        st_in    = ST_SATURATED;
                        state_in = S_IDLE;
                     end
                  end else if ((occ_ff != '0) &&
                               ((op_ff == OP_SIGNAL_ID) || count_ff[COUNT_W-1])) begin
                     count_in = count_ff + COUNT_W'(1);
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = S_SCAN;
                  end else if (out_free) begin
                     count_in = count_ff + COUNT_W'(1);
                     emit     = 1'b1;
                     st_in    = ST_NONE;
                     state_in = S_IDLE;
                  end
               end
               OP_REOPEN: begin
                  count_in = {{(COUNT_W - INIT_W){1'b0}}, init_ff};
                  if (occ_ff != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = S_DEAD;
                  end else if (out_free) begin
                     emit     = 1'b1;
                     st_in    = ST_NONE;
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SCAN: begin
            if ((op_ff == OP_SIGNAL) || (rd_data == tid_ff)) begin
               rel_in = rd_data;
               if (more) begin
                  rd_en    = 1'b1;
                  idx_in   = idx_nx[PTR_W-1:0];
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end else if (more) begin
               rd_en  = 1'b1;
               idx_in = idx_nx[PTR_W-1:0];
            end else if (out_free) begin
               emit     = 1'b1;
               st_in    = ST_NONE;
               state_in = S_IDLE;
            end
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - PTR_W'(1);
            wr_data = rd_data;
            if (more) begin
               rd_en  = 1'b1;
               idx_in = idx_nx[PTR_W-1:0];
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               st_in    = ST_RELEASED;
               id_in    = rel_ff;
               occ_in   = occ_ff - CNT_W'(1);
               state_in = S_IDLE;
            end
         end
         S_DEAD: begin
            if (out_free) begin
               emit    = 1'b1;
               st_in   = ST_DEAD;
               id_in   = rd_data;
               last_in = !more;
               if (more) begin
                  rd_en  = 1'b1;
                  idx_in = idx_nx[PTR_W-1:0];
               end else begin
                  occ_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         occ_ff       <= '0;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         occ_ff   <= occ_in;
         if (csr_valid) begin
            init_ff <= csr_init_value;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rel_ff <= rel_in;
      op_ff  <= op_in;
      tid_ff <= tid_in;
      if (emit) begin
         rsp_status_ff <= st_in;
         rsp_id_ff     <= id_in;
         rsp_count_ff  <= count_in[COUNT_NOW_W-1:0];
         rsp_last_ff   <= last_in;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_released_id = rsp_id_ff;
   assign rsp_count_now   = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   `ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= CNT_W'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_count_covers_queue, clock, reset, !balance[COUNT_W])
   `ASSERT_NEXT(a_block_grows_queue, clock, reset, emit && (st_in == ST_BLOCKED), occ_ff == CNT_W'($past(occ_ff) + CNT_W'(1)))

endmodule
